// ===== rtl/core/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// npc_pkg: shared types and constants for the nearest palette colour unit
// Codes, command and status structs, and the fixed sixteen-colour EGA table.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int unsigned COMP_W      = 8;
  localparam int unsigned RGB_W       = 24;
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned PCOUNT_W    = 9;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned SQ_W        = 16;
  localparam int unsigned DIST_W      = 19;
  localparam int unsigned EGA_COLORS  = 16;
  localparam int unsigned EGA_IDX_W   = 4;

  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(4 * 256 * 256);
  localparam logic [COLOR_W-1:0] ALL_ONES  = 32'hffff_ffff;

  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = 8'd1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MODE_INDEXED = 2'd0,
    MODE_DIRECT  = 2'd1,
    MODE_EGA     = 2'd2,
    MODE_UNKNOWN = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    RES_PICK,
    RES_QUERY,
    RES_ONES
  } res_sel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic     wr;
    logic     start;
    logic     issue;
    logic     src_ega;
    logic     load_out;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic pipe_idle;
  } sts_t;

  localparam logic [RGB_W-1:0] EGA_TABLE [EGA_COLORS] = '{
    24'h000000, 24'h0000aa, 24'h00aa00, 24'h00aaaa,
    24'haa0000, 24'haa00aa, 24'haa5500, 24'haaaaaa,
    24'h555555, 24'h5555ff, 24'h55ff55, 24'h55ffff,
    24'hff5555, 24'hff55ff, 24'hffff55, 24'hffffff
  };

  function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                 input logic [COMP_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== rtl/core/npc_if.sv =====
// ----------------------------------------------------------------------------
// npc_if: handshake channels of the nearest palette colour unit
// Request, response and register-write channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface npc_req_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [npc_pkg::COMP_W-1:0]  entry_index;
  logic [npc_pkg::COMP_W-1:0]  entry_red;
  logic [npc_pkg::COMP_W-1:0]  entry_green;
  logic [npc_pkg::COMP_W-1:0]  entry_blue;
  logic [npc_pkg::COLOR_W-1:0] desired_color;

  modport source (output valid, op, entry_index, entry_red, entry_green, entry_blue,
                  desired_color, input ready);
  modport sink   (input valid, op, entry_index, entry_red, entry_green, entry_blue,
                  desired_color, output ready);
endinterface

interface npc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [npc_pkg::COLOR_W-1:0] chosen_color;

  modport source (output valid, chosen_color, input ready);
  modport sink   (input valid, chosen_color, output ready);
endinterface

interface npc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [npc_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [npc_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/core/nearest_palette_color_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_unit: nearest-colour palette quantiser
// Stores an RGB palette and answers colour queries by squared RGB distance.
// ----------------------------------------------------------------------------
// A write item stores one palette entry if its index is below the depth, with no response.
// A query is answered from the mode register: in indexed mode the palette
// memory is read one entry per cycle through a three-stage distance pipeline,
// scanning N entries (N = palette_count, capped at the depth); EGA text mode
// scans its sixteen fixed colours; direct and unknown modes answer without a
// scan. One query is in flight at a time, and a finished result waits in an
// output register so the next transfer can be taken before it is collected.
module nearest_palette_color_unit #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  npc_req_if.sink   req_i,
  npc_rsp_if.source rsp_o,
  npc_cfg_if.sink   cfg_i
);
  import npc_pkg::*;

  localparam int unsigned IdxW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned ScanW = (IdxW > EGA_IDX_W) ? IdxW : EGA_IDX_W;

  cmd_t             cmd;
  sts_t             sts;
  logic [ScanW-1:0] scan_addr;

  npc_ctrl #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .SCAN_W        (ScanW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_op_i     (req_i.op),
    .in_ready_o  (req_i.ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.reg_index),
    .cfg_data_i  (cfg_i.wdata),
    .cfg_ready_o (cfg_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .scan_addr_o (scan_addr)
  );

  npc_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .IDX_W         (IdxW),
    .SCAN_W        (ScanW)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .scan_addr_i     (scan_addr),
    .entry_index_i   (req_i.entry_index),
    .entry_red_i     (req_i.entry_red),
    .entry_green_i   (req_i.entry_green),
    .entry_blue_i    (req_i.entry_blue),
    .desired_color_i (req_i.desired_color),
    .sts_o           (sts),
    .chosen_color_o  (rsp_o.chosen_color)
  );

  a_load_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.pipe_idle)
    else $error("result loaded while distance pipeline busy");

  a_start_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> sts.pipe_idle)
    else $error("query started with stale pipeline contents");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> rsp_o.valid)
    else $error("loaded result not presented");

endmodule

// ===== rtl/core/npc_datapath.sv =====
// ----------------------------------------------------------------------------
// npc_datapath: palette store and distance pipeline
// Holds the palette memory, squares the component differences one entry per
// cycle and keeps the running minimum and its index, plus the result register.
// ----------------------------------------------------------------------------
module npc_datapath #(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned IDX_W         = 8,
  parameter int unsigned SCAN_W        = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  npc_pkg::cmd_t               cmd_i,
  input  logic [SCAN_W-1:0]           scan_addr_i,
  input  logic [npc_pkg::COMP_W-1:0]  entry_index_i,
  input  logic [npc_pkg::COMP_W-1:0]  entry_red_i,
  input  logic [npc_pkg::COMP_W-1:0]  entry_green_i,
  input  logic [npc_pkg::COMP_W-1:0]  entry_blue_i,
  input  logic [npc_pkg::COLOR_W-1:0] desired_color_i,
  output npc_pkg::sts_t               sts_o,
  output logic [npc_pkg::COLOR_W-1:0] chosen_color_o
);
  import npc_pkg::*;

  logic [RGB_W-1:0]   mem [PALETTE_DEPTH];
  logic [RGB_W-1:0]   mem_rd_q;
  logic [RGB_W-1:0]   ega_rd_q;
  logic [COLOR_W-1:0] query_q;
  logic               s1_v_q, s2_v_q;
  logic               s1_ega_q;
  logic [SCAN_W-1:0]  s1_idx_q, s2_idx_q;
  logic [SQ_W-1:0]    sq_r_q, sq_g_q, sq_b_q;
  logic [DIST_W-1:0]  best_q;
  logic [SCAN_W-1:0]  pick_q;
  logic [COLOR_W-1:0] out_q;

  logic               wr_ok;
  logic [RGB_W-1:0]   entry;
  logic [COMP_W-1:0]  d_r, d_g, d_b;
  logic [DIST_W-1:0]  dist_sum;

  assign wr_ok = cmd_i.wr && ({1'b0, entry_index_i} < 9'(PALETTE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[entry_index_i[IDX_W-1:0]] <= {entry_red_i, entry_green_i, entry_blue_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      mem_rd_q <= mem[scan_addr_i[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      ega_rd_q <= EGA_TABLE[scan_addr_i[EGA_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.issue;
      s2_v_q <= s1_v_q;
    end
  end

  assign entry    = s1_ega_q ? ega_rd_q : mem_rd_q;
  assign d_r      = abs_diff(query_q[23:16], entry[23:16]);
  assign d_g      = abs_diff(query_q[15:8],  entry[15:8]);
  assign d_b      = abs_diff(query_q[7:0],   entry[7:0]);
  assign dist_sum = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      query_q <= desired_color_i;
    end
    if (cmd_i.issue) begin
      s1_ega_q <= cmd_i.src_ega;
      s1_idx_q <= scan_addr_i;
    end
    if (s1_v_q) begin
      sq_r_q   <= SQ_W'(d_r) * SQ_W'(d_r);
      sq_g_q   <= SQ_W'(d_g) * SQ_W'(d_g);
      sq_b_q   <= SQ_W'(d_b) * SQ_W'(d_b);
      s2_idx_q <= s1_idx_q;
    end
    if (cmd_i.start) begin
      best_q <= DIST_START;
      pick_q <= '0;
    end else if (s2_v_q && (dist_sum < best_q)) begin
      best_q <= dist_sum;
      pick_q <= s2_idx_q;
    end
    if (cmd_i.load_out) begin
      case (cmd_i.res_sel)
        RES_PICK:  out_q <= COLOR_W'(pick_q);
        RES_QUERY: out_q <= query_q;
        default:   out_q <= ALL_ONES;
      endcase
    end
  end

  assign sts_o.pipe_idle = !s1_v_q && !s2_v_q;
  assign chosen_color_o  = out_q;

endmodule

// ===== rtl/core/npc_ctrl.sv =====
// ----------------------------------------------------------------------------
// npc_ctrl: sequencer of the nearest palette colour unit
// Holds the mode and count registers, steps the scan address, waits for the
// distance pipeline to drain and hands the result to the output register.
// ----------------------------------------------------------------------------
module npc_ctrl #(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned SCAN_W        = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_op_i,
  output logic                           in_ready_o,
  input  logic                           cfg_valid_i,
  input  logic [npc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [npc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           cfg_ready_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  npc_pkg::sts_t                  sts_i,
  output npc_pkg::cmd_t                  cmd_o,
  output logic [SCAN_W-1:0]              scan_addr_o
);
  import npc_pkg::*;

  ctrl_state_e         state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [PCOUNT_W-1:0] count_q, count_d;
  logic [SCAN_W-1:0]   cnt_q, cnt_d;
  logic [SCAN_W-1:0]   last_q, last_d;
  logic                src_ega_q, src_ega_d;
  res_sel_e            res_sel_q, res_sel_d;
  logic                out_valid_q, out_valid_d;

  logic                accept;
  logic [PCOUNT_W-1:0] count_sat;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign count_sat   = (count_q > PCOUNT_W'(PALETTE_DEPTH)) ? PCOUNT_W'(PALETTE_DEPTH)
                                                            : count_q;
  assign scan_addr_o = cnt_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_INDEXED;
      count_q     <= '0;
      cnt_q       <= '0;
      last_q      <= '0;
      src_ega_q   <= 1'b0;
      res_sel_q   <= RES_PICK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      src_ega_q   <= src_ega_d;
      res_sel_q   <= res_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    count_d     = count_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    src_ega_d   = src_ega_q;
    res_sel_d   = res_sel_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.src_ega = src_ega_q;
    cmd_o.res_sel = res_sel_q;

    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_COLOR_MODE) begin
        mode_d = mode_e'(cfg_data_i[1:0]);
      end else if (cfg_index_i == CFG_PALETTE_COUNT) begin
        count_d = cfg_data_i[PCOUNT_W-1:0];
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_op_i == OP_WRITE) begin
            cmd_o.wr = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            cnt_d       = '0;
            unique case (mode_q)
              MODE_INDEXED: begin
                res_sel_d = RES_PICK;
                src_ega_d = 1'b0;
                last_d    = SCAN_W'(count_sat - PCOUNT_W'(1));
                state_d   = (count_sat == '0) ? ST_FINISH : ST_SCAN;
              end
              MODE_DIRECT: begin
                res_sel_d = RES_QUERY;
                state_d   = ST_FINISH;
              end
              MODE_EGA: begin
                res_sel_d = RES_PICK;
                src_ega_d = 1'b1;
                last_d    = SCAN_W'(EGA_COLORS - 1);
                state_d   = ST_SCAN;
              end
              default: begin
                res_sel_d = RES_ONES;
                state_d   = ST_FINISH;
              end
            endcase
          end
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (cnt_q == last_q) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + SCAN_W'(1);
        end
      end
      ST_DRAIN: begin
        if (sts_i.pipe_idle) begin
          state_d = ST_FINISH;
        end
      end
      default: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
    endcase

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

endmodule
